// ===== hdl/svpwm_pkg.sv =====
// Shared types and constants for the space vector PWM timing unit.
// No dependencies; used by every module in hdl/.
package svpwm_pkg;

    // Default fraction width of the internal scale.
    localparam int FRAC_BITS_DEF = 15;

    // 1/sqrt(3) in Q0.31, rounded to the chosen fraction width where it is used.
    localparam longint RECIP_SQRT3_Q31 = 64'sd1239850262;

    // Output code that stands for 1.0.
    localparam logic [15:0] TIME_ONE = 16'd32768;

    // Sextant codes.
    localparam logic [2:0] SEXT_1 = 3'd1;
    localparam logic [2:0] SEXT_2 = 3'd2;
    localparam logic [2:0] SEXT_3 = 3'd3;
    localparam logic [2:0] SEXT_4 = 3'd4;
    localparam logic [2:0] SEXT_5 = 3'd5;
    localparam logic [2:0] SEXT_6 = 3'd6;

    typedef struct packed {
        logic signed [15:0] alpha;
        logic signed [15:0] beta;
    } svpwm_in_t;

    typedef struct packed {
        logic [15:0] time_a;
        logic [15:0] time_b;
        logic [15:0] time_c;
        logic [2:0]  sextant;
        logic        valid_res;
    } svpwm_out_t;

endpackage

// ===== hdl/space_vector_pwm_timing_unit.sv =====
// Top level of the space vector PWM timing unit.
// Depends on svpwm_pkg, svpwm_sector and svpwm_timing.
//
// This unit turns one alpha-beta voltage vector (signed Q1.15 on each axis) into the
// three phase rising-edge times of a centered space vector PWM period, plus the sextant
// (1 to 6) the vector lies in. Times are unsigned with 32768 meaning a full period and
// are rounded to nearest with halves going up. When the vector asks for more than the
// inverter can give, each time is clamped into 0 to 32768 and valid_res drops to 0;
// the sextant is still reported. A vector on the positive alpha axis counts as sextant
// 1. A vector exactly on a sextant boundary stays on the side that the strict comparison
// between the scaled beta and alpha terms leaves it on: in the upper half plane that is
// the lower-numbered sextant, in the lower half plane the higher-numbered one (6 rather
// than 5, 5 rather than 4). The unit accepts one beat per clock cycle while the result
// side is ready. A beat goes through the input register into the result register, which
// offers its result, and it waits in the input register while the held result is not
// taken. The input register feeds the multiply by 1/sqrt(3), the sextant compare and
// the add chain that places the zero-vector time; the result register closes that
// path, so this logic sets the clock rate. A held result does not stop the input
// register from taking a new beat until both registers are full. The internal scale
// follows FRAC_BITS (8 to 30), which sets the precision of 1/sqrt(3).
module space_vector_pwm_timing_unit #(
    parameter int FRAC_BITS = svpwm_pkg::FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  svpwm_pkg::svpwm_in_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output svpwm_pkg::svpwm_out_t m_data
);

    localparam int W = FRAC_BITS + 22;

    // Input register stage.
    logic                  in_vld_reg;
    logic                  in_vld_next;
    svpwm_pkg::svpwm_in_t  in_data_reg;

    // Result register stage.
    logic                  m_valid_reg;
    logic                  m_valid_next;
    svpwm_pkg::svpwm_out_t m_data_reg;

    logic                  advance;
    logic [2:0]            sextant;
    logic signed [W-1:0]   dt_first;
    logic signed [W-1:0]   dt_second;
    svpwm_pkg::svpwm_out_t res;

    // The input register moves on whenever the result register is empty or being read.
    assign advance = in_vld_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;

    always_comb begin
        if (s_valid && s_ready) begin
            in_vld_next = 1'b1;
        end else if (advance) begin
            in_vld_next = 1'b0;
        end else begin
            in_vld_next = in_vld_reg;
        end

        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            m_data_reg <= res;
        end
    end

    svpwm_sector #(
        .FRAC_BITS (FRAC_BITS)
    ) u_sector (
        .in_beat   (in_data_reg),
        .sextant   (sextant),
        .dt_first  (dt_first),
        .dt_second (dt_second)
    );

    svpwm_timing #(
        .FRAC_BITS (FRAC_BITS)
    ) u_timing (
        .sextant   (sextant),
        .dt_first  (dt_first),
        .dt_second (dt_second),
        .res       (res)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A beat that leaves the input register must show up as a result next cycle.
    a_advance_delivers: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("input beat advanced but no result appeared");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // Sextant is always one of the six sectors.
    a_sextant_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.sextant >= svpwm_pkg::SEXT_1 &&
                     m_data.sextant <= svpwm_pkg::SEXT_6))
        else $error("sextant out of range");

    // Clamping keeps every time at or below one full period.
    a_time_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.time_a <= svpwm_pkg::TIME_ONE &&
                     m_data.time_b <= svpwm_pkg::TIME_ONE &&
                     m_data.time_c <= svpwm_pkg::TIME_ONE))
        else $error("phase time above full period");

    // In the first sextant phase A switches first and phase C last.
    a_sext1_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.sextant == svpwm_pkg::SEXT_1) |->
            (m_data.time_a <= m_data.time_b && m_data.time_b <= m_data.time_c))
        else $error("phase order wrong in first sextant");

endmodule

// ===== hdl/svpwm_sector.sv =====
// Sextant detection and active-vector on-times for the space vector PWM timing unit.
// Depends on svpwm_pkg.
module svpwm_sector #(
    parameter int FRAC_BITS = svpwm_pkg::FRAC_BITS_DEF
) (
    input  svpwm_pkg::svpwm_in_t          in_beat,
    output logic [2:0]                    sextant,
    output logic signed [FRAC_BITS+21:0]  dt_first,
    output logic signed [FRAC_BITS+21:0]  dt_second
);

    localparam int W = FRAC_BITS + 22;
    localparam longint RECIP_SQRT3 =
        (svpwm_pkg::RECIP_SQRT3_Q31 + (64'sd1 <<< (30 - FRAC_BITS))) >>> (31 - FRAC_BITS);
    localparam logic signed [W-1:0] RECIP_C = W'(RECIP_SQRT3);

    logic signed [W-1:0] a_ext;
    logic signed [W-1:0] b_ext;
    logic signed [W-1:0] x;
    logic signed [W-1:0] y;
    logic signed [W-1:0] neg_y;

    assign a_ext = {{(W-16){in_beat.alpha[15]}}, in_beat.alpha};
    assign b_ext = {{(W-16){in_beat.beta[15]}}, in_beat.beta};

    // Both terms sit at the internal scale where 2^(FRAC_BITS+16) is 1.0.
    assign x     = a_ext <<< (FRAC_BITS + 1);
    assign y     = (b_ext * RECIP_C) <<< 1;
    assign neg_y = -y;

    // Zero beta counts as the upper half-plane, zero alpha as the right half-plane.
    always_comb begin
        case ({in_beat.beta[15], in_beat.alpha[15]})
            2'b00:   sextant = (y > x)     ? svpwm_pkg::SEXT_2 : svpwm_pkg::SEXT_1;
            2'b01:   sextant = (neg_y > x) ? svpwm_pkg::SEXT_3 : svpwm_pkg::SEXT_2;
            2'b10:   sextant = (neg_y > x) ? svpwm_pkg::SEXT_5 : svpwm_pkg::SEXT_6;
            default: sextant = (y > x)     ? svpwm_pkg::SEXT_4 : svpwm_pkg::SEXT_5;
        endcase
    end

    // On-times in the order in which they stack on top of the zero-vector half.
    always_comb begin
        case (sextant)
            svpwm_pkg::SEXT_1: begin
                dt_first  = x - y;
                dt_second = y <<< 1;
            end
            svpwm_pkg::SEXT_2: begin
                dt_first  = y - x;
                dt_second = x + y;
            end
            svpwm_pkg::SEXT_3: begin
                dt_first  = y <<< 1;
                dt_second = neg_y - x;
            end
            svpwm_pkg::SEXT_4: begin
                dt_first  = neg_y <<< 1;
                dt_second = y - x;
            end
            svpwm_pkg::SEXT_5: begin
                dt_first  = neg_y - x;
                dt_second = x - y;
            end
            default: begin
                dt_first  = x + y;
                dt_second = neg_y <<< 1;
            end
        endcase
    end

endmodule

// ===== hdl/svpwm_timing.sv =====
// Zero-vector centering, phase assignment, rounding, clamping and range flag.
// Depends on svpwm_pkg.
module svpwm_timing #(
    parameter int FRAC_BITS = svpwm_pkg::FRAC_BITS_DEF
) (
    input  logic [2:0]                    sextant,
    input  logic signed [FRAC_BITS+21:0]  dt_first,
    input  logic signed [FRAC_BITS+21:0]  dt_second,
    output svpwm_pkg::svpwm_out_t         res
);

    localparam int W = FRAC_BITS + 22;
    localparam logic signed [W-1:0]       UNIT     = W'(1) <<< (FRAC_BITS + 16);
    localparam logic [FRAC_BITS+16:0]     RND_HALF = (FRAC_BITS + 17)'(1) << FRAC_BITS;

    logic signed [W-1:0] t_zero;
    logic signed [W-1:0] t_mid;
    logic signed [W-1:0] t_top;
    logic [15:0]         q_zero;
    logic [15:0]         q_mid;
    logic [15:0]         q_top;

    function automatic logic [15:0] to_q15(input logic signed [W-1:0] t);
        logic [FRAC_BITS+16:0] rnd;
        rnd = t[FRAC_BITS+16:0] + RND_HALF;
        if (t < 0) begin
            return 16'd0;
        end else if (t > UNIT) begin
            return svpwm_pkg::TIME_ONE;
        end else begin
            return rnd[FRAC_BITS+16:FRAC_BITS+1];
        end
    endfunction

    function automatic logic in_unit(input logic signed [W-1:0] t);
        return (t >= 0) && (t <= UNIT);
    endfunction

    // All terms are even, so the halving is exact.
    assign t_zero = (UNIT - dt_first - dt_second) >>> 1;
    assign t_mid  = t_zero + dt_first;
    assign t_top  = t_mid + dt_second;

    assign q_zero = to_q15(t_zero);
    assign q_mid  = to_q15(t_mid);
    assign q_top  = to_q15(t_top);

    always_comb begin
        res.sextant   = sextant;
        res.valid_res = in_unit(t_zero) && in_unit(t_mid) && in_unit(t_top);
        case (sextant)
            svpwm_pkg::SEXT_1: begin
                res.time_a = q_zero;
                res.time_b = q_mid;
                res.time_c = q_top;
            end
            svpwm_pkg::SEXT_2: begin
                res.time_b = q_zero;
                res.time_a = q_mid;
                res.time_c = q_top;
            end
            svpwm_pkg::SEXT_3: begin
                res.time_b = q_zero;
                res.time_c = q_mid;
                res.time_a = q_top;
            end
            svpwm_pkg::SEXT_4: begin
                res.time_c = q_zero;
                res.time_b = q_mid;
                res.time_a = q_top;
            end
            svpwm_pkg::SEXT_5: begin
                res.time_c = q_zero;
                res.time_a = q_mid;
                res.time_b = q_top;
            end
            default: begin
                res.time_a = q_zero;
                res.time_c = q_mid;
                res.time_b = q_top;
            end
        endcase
    end

endmodule
